>>> rtl/sha_pkg.sv
// ----------------------------------------------------------------------------
// sha_pkg
// Shared types, constants and round functions of the SHA-256 stream hasher.
// ----------------------------------------------------------------------------
package sha_pkg;

    localparam int BLOCK_BYTES = 64;
    localparam int WORDS       = 8;

    localparam logic [7:0] PAD_BYTE  = 8'h80;
    localparam logic [5:0] LEN_START = 6'd56;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LOAD,
        ST_ROUND,
        ST_FINAL,
        ST_EMIT
    } state_t;

    // request from the controller to the compression core
    typedef struct packed {
        logic start;
        logic clear_h;
    } core_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } core_sts_t;

    function automatic logic [31:0] init_h(input logic [2:0] i);
        logic [31:0] r;
        case (i)
            3'd0:    r = 32'h6a09e667;
            3'd1:    r = 32'hbb67ae85;
            3'd2:    r = 32'h3c6ef372;
            3'd3:    r = 32'ha54ff53a;
            3'd4:    r = 32'h510e527f;
            3'd5:    r = 32'h9b05688c;
            3'd6:    r = 32'h1f83d9ab;
            default: r = 32'h5be0cd19;
        endcase
        return r;
    endfunction

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] ror(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage

>>> rtl/sha_core.sv
// ----------------------------------------------------------------------------
// sha_core
// One-round-per-cycle SHA-256 compression. Message words come from the block
// memory as 32-bit reads; the schedule runs in a 16-word sliding window and
// the hash words live in a small 8-entry memory read back for the final add.
// ----------------------------------------------------------------------------
module sha_core (
    input  logic                clk,
    input  logic                rst_n,
    input  sha_pkg::core_req_t  req,
    output sha_pkg::core_sts_t  sts,
    // block memory word read port
    output logic [3:0]          wrd_addr,
    input  logic [31:0]         wrd_data,
    // digest read port
    input  logic [2:0]          h_addr,
    output logic [31:0]         h_data
);

    logic [31:0] h_mem [8];
    logic [7:0]  h_valid_reg;   // entry not valid reads as initial value

    logic [6:0]  t_reg, t_next;
    logic        run_reg, run_next;
    logic        fin_reg, fin_next;
    logic [2:0]  fin_idx_reg, fin_idx_next;
    logic [31:0] w_win [16];
    logic [31:0] v_reg [8];
    logic [31:0] h_rd_reg;

    logic [31:0] w_t, g0, g1, w_new;
    logic [31:0] big1, choose, sum1, big0, major;
    logic [31:0] h_cur [8];

    always_comb
    begin
        for (int i = 0; i < 8; i++)
            h_cur[i] = h_valid_reg[i] ? h_mem[i] : sha_pkg::init_h(3'(i));
    end

    // issue block-memory word reads in the cycle before their use
    assign wrd_addr = t_reg[3:0];

    // schedule: first 16 words from memory, then sliding window expansion
    assign g0    = sha_pkg::ror(w_win[1], 7) ^ sha_pkg::ror(w_win[1], 18) ^ (w_win[1] >> 3);
    assign g1    = sha_pkg::ror(w_win[14], 17) ^ sha_pkg::ror(w_win[14], 19)
                   ^ (w_win[14] >> 10);
    assign w_new = w_win[0] + g0 + w_win[9] + g1;
    assign w_t   = (t_reg <= 7'd16) ? wrd_data : w_new;

    assign big1   = sha_pkg::ror(v_reg[4], 6) ^ sha_pkg::ror(v_reg[4], 11)
                    ^ sha_pkg::ror(v_reg[4], 25);
    assign choose = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
    assign sum1   = v_reg[7] + big1 + choose + sha_pkg::ROUND_K[6'(t_reg - 7'd1)] + w_t;
    assign big0   = sha_pkg::ror(v_reg[0], 2) ^ sha_pkg::ror(v_reg[0], 13)
                    ^ sha_pkg::ror(v_reg[0], 22);
    assign major  = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);

    // control: t counts 0 (address prime), 1..64 rounds
    always_comb
    begin
        run_next     = run_reg;
        t_next       = t_reg;
        fin_next     = fin_reg;
        fin_idx_next = fin_idx_reg;
        if (req.start)
        begin
            run_next = 1'b1;
            t_next   = 7'd0;
        end
        else if (run_reg)
        begin
            t_next = t_reg + 7'd1;
            if (t_reg == 7'd64)
            begin
                run_next     = 1'b0;
                fin_next     = 1'b1;
                fin_idx_next = 3'd0;
            end
        end
        else if (fin_reg)
        begin
            fin_idx_next = fin_idx_reg + 3'd1;
            if (fin_idx_reg == 3'd7)
                fin_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg     <= 1'b0;
            t_reg       <= '0;
            fin_reg     <= 1'b0;
            fin_idx_reg <= '0;
            h_valid_reg <= '0;
        end
        else
        begin
            run_reg     <= run_next;
            t_reg       <= t_next;
            fin_reg     <= fin_next;
            fin_idx_reg <= fin_idx_next;
            if (req.clear_h)
                h_valid_reg <= '0;
            else if (fin_reg)
                h_valid_reg[fin_idx_reg] <= 1'b1;
        end
    end

    // working variables and schedule window
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            for (int i = 0; i < 8; i++)
                v_reg[i] <= h_cur[i];
        end
        else if (run_reg && t_reg != 7'd0)
        begin
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + sum1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= sum1 + big0 + major;
            for (int i = 0; i < 15; i++)
                w_win[i] <= w_win[i+1];
            w_win[15] <= w_t;
        end
    end

    // hash memory: add back one word per cycle, read port for digest
    always_ff @(posedge clk)
    begin
        if (fin_reg)
            h_mem[fin_idx_reg] <= h_cur[fin_idx_reg] + v_reg[fin_idx_reg];
        h_rd_reg <= h_cur[h_addr];
    end

    assign h_data   = h_rd_reg;
    assign sts.busy = run_reg | fin_reg;
    assign sts.done = fin_reg && fin_idx_reg == 3'd7;

endmodule

>>> rtl/sha256_stream_hasher_top.sv
// ----------------------------------------------------------------------------
// sha256_stream_hasher_top
// Present bytes are accepted in idle and written to the block memory; a full
// block starts a compression (address prime, rounds, then add-back of the eight
// hash words), during which no bytes are accepted. End of message runs padding
// (one write per pad byte) and one or two compressions, then sends eight digest
// transfers. Rate set by the one-round-per-cycle core and the single block-memory
// write port. Reset returns hash words to initial values.
// ----------------------------------------------------------------------------
module sha256_stream_hasher_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] byte_present
    input  logic        s_tlast,   // end_of_message
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] digest_word, [34:32] word_index
    output logic        m_tlast    // last_word
);

    sha_pkg::state_t    state_reg, state_next;
    sha_pkg::core_req_t req;
    sha_pkg::core_sts_t sts;

    logic [31:0] mem [sha_pkg::BLOCK_BYTES / 4];
    logic [31:0] wrd_reg;
    logic [3:0]  wrd_addr;
    logic [5:0]  pend_reg, pend_next;
    logic [63:0] bits_reg, bits_next;
    logic [5:0]  pad_reg, pad_next;
    logic        two_reg, two_next;     // padding needs an extra block
    logic        eom_reg, eom_next;
    logic [2:0]  idx_reg, idx_next;
    logic        we;
    logic [5:0]  waddr;
    logic [7:0]  wdata;
    logic [31:0] h_data;
    logic [2:0]  h_addr;
    logic        out_vld_reg, out_vld_next;
    logic        accept;

    assign accept = s_tvalid && s_tready;

    sha_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .sts      (sts),
        .wrd_addr (wrd_addr),
        .wrd_data (wrd_reg),
        .h_addr   (h_addr),
        .h_data   (h_data)
    );

    // block memory: 32-bit big-endian words, byte-lane write, registered read
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr[5:2]][{~waddr[1:0], 3'd0} +: 8] <= wdata;
        wrd_reg <= mem[wrd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= sha_pkg::ST_IDLE;
            pend_reg    <= '0;
            bits_reg    <= '0;
            pad_reg     <= '0;
            two_reg     <= 1'b0;
            eom_reg     <= 1'b0;
            idx_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            pend_reg    <= pend_next;
            bits_reg    <= bits_next;
            pad_reg     <= pad_next;
            two_reg     <= two_next;
            eom_reg     <= eom_next;
            idx_reg     <= idx_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // sequence bytes, padding, compressions and digest transfers
    always_comb
    begin
        state_next   = state_reg;
        pend_next    = pend_reg;
        bits_next    = bits_reg;
        pad_next     = pad_reg;
        two_next     = two_reg;
        eom_next     = eom_reg;
        idx_next     = idx_reg;
        out_vld_next = out_vld_reg;
        s_tready     = 1'b0;
        req          = '0;
        we           = 1'b0;
        waddr        = pend_reg;
        wdata        = s_tdata;
        h_addr       = idx_reg;
        case (state_reg)
            sha_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (accept)
                begin
                    eom_next = s_tlast;
                    if (s_tuser)
                    begin
                        we        = 1'b1;
                        pend_next = pend_reg + 6'd1;
                        bits_next = bits_reg + 64'd8;
                    end
                    if (s_tuser && pend_reg == 6'd63)
                    begin
                        req.start  = 1'b1;
                        state_next = sha_pkg::ST_ROUND;
                    end
                    else if (s_tlast)
                    begin
                        pad_next   = s_tuser ? pend_reg + 6'd1 : pend_reg;
                        two_next   = (s_tuser ? pend_reg + 6'd1 : pend_reg)
                                     >= sha_pkg::LEN_START;
                        state_next = sha_pkg::ST_PAD;
                    end
                end
            end
            sha_pkg::ST_ROUND:
            begin
                if (sts.done)
                begin
                    if (eom_reg)
                    begin
                        pad_next   = pend_reg;
                        state_next = sha_pkg::ST_PAD;
                    end
                    else
                        state_next = sha_pkg::ST_IDLE;
                end
            end
            sha_pkg::ST_PAD:
            begin
                // write one pad byte per cycle: 0x80 at the end, then zeros/length;
                // the extra block runs with two set and pend cleared
                we    = 1'b1;
                waddr = pad_reg;
                if (pad_reg == pend_reg && !(pend_reg == 6'd0 && two_reg))
                    wdata = sha_pkg::PAD_BYTE;
                else if (pad_reg >= sha_pkg::LEN_START && !(two_reg && pend_reg != 6'd0))
                    wdata = 8'(bits_reg >> (6'd56 - {pad_reg[2:0], 3'd0}));
                else
                    wdata = 8'd0;
                pad_next = pad_reg + 6'd1;
                if (pad_reg == 6'd63)
                begin
                    req.start  = 1'b1;
                    state_next = sha_pkg::ST_LOAD;
                end
            end
            sha_pkg::ST_LOAD:
            begin
                if (sts.done)
                begin
                    if (two_reg && pend_reg != 6'd0)
                    begin
                        pend_next  = 6'd0;
                        pad_next   = 6'd0;
                        state_next = sha_pkg::ST_PAD;
                    end
                    else
                    begin
                        two_next   = 1'b0;
                        idx_next   = 3'd0;
                        state_next = sha_pkg::ST_FINAL;
                    end
                end
            end
            sha_pkg::ST_FINAL:
            begin
                // wait state for the registered hash read
                out_vld_next = 1'b1;
                state_next   = sha_pkg::ST_EMIT;
            end
            sha_pkg::ST_EMIT:
            begin
                if (m_tready)
                begin
                    if (idx_reg == 3'd7)
                    begin
                        out_vld_next = 1'b0;
                        req.clear_h  = 1'b1;
                        pend_next    = '0;
                        bits_next    = '0;
                        eom_next     = 1'b0;
                        state_next   = sha_pkg::ST_IDLE;
                    end
                    else
                    begin
                        idx_next     = idx_reg + 3'd1;
                        h_addr       = idx_reg + 3'd1;
                        out_vld_next = 1'b0;
                        state_next   = sha_pkg::ST_FINAL;
                    end
                end
            end
            default: state_next = sha_pkg::ST_IDLE;
        endcase
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {5'd0, idx_reg, h_data};
    assign m_tlast  = idx_reg == 3'd7;

endmodule
